// ===== rtl/ckhf_pkg.sv =====
// ----------------------------------------------------------------------------
// ckhf_pkg
// Shared types and constants for the canonical k-mer hash filter.
// ----------------------------------------------------------------------------
package ckhf_pkg;

  localparam int MAX_K      = 32;
  localparam int KLEN_W     = 6;
  localparam int HASH_W     = 64;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 64;
  localparam int QDEPTH     = 4;
  localparam int QPTR_W     = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_KMER_LENGTH   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HASH_THRESHOLD = 2'd1;

  localparam logic [KLEN_W-1:0] KMER_RESET = 6'd21;
  localparam logic [KLEN_W-1:0] KMER_MAX   = 6'd32;

  localparam logic [63:0] FMIX_C1 = 64'hff51afd7ed558ccd;
  localparam logic [63:0] FMIX_C2 = 64'hc4ceb9fe1a85ec53;

  typedef struct packed {
    logic [7:0] base_char;
    logic       last_base;
  } in_word_t;

  typedef struct packed {
    logic [HASH_W-1:0] canonical_hash;
    logic              in_sketch;
  } out_word_t;

  typedef struct packed {
    logic [HASH_W-1:0] fwd;
    logic [HASH_W-1:0] rev;
  } win_pair_t;

  typedef struct packed {
    logic       valid;
    logic [1:0] code;
  } base_code_t;

  function automatic base_code_t decode_base(input logic [7:0] c);
    base_code_t r;
    r.valid = 1'b1;
    unique case (c)
      8'h41, 8'h61: r.code = 2'd0;
      8'h43, 8'h63: r.code = 2'd1;
      8'h47, 8'h67: r.code = 2'd2;
      8'h54, 8'h74: r.code = 2'd3;
      default: begin
        r.valid = 1'b0;
        r.code  = 2'd0;
      end
    endcase
    return r;
  endfunction

endpackage

// ===== rtl/canonical_kmer_hash_filter_unit.sv =====
// ----------------------------------------------------------------------------
// canonical_kmer_hash_filter_unit
// Canonical k-mer FracMinHash front end with fmix64 hashing.
// ----------------------------------------------------------------------------
//
//  channel   handshake            word                 direction
//  input     push / full          in_word  (in_word_t)  into block
//  result    pop / empty          out_word (out_word_t) out of block
//  config    cfg_we               cfg_index, cfg_wdata  into block
//
//  The front takes one base per cycle while its queue has room; bases that
//  complete no window (or are invalid) leave nothing behind.
//  In the back end, one 32x32 multiplier per lane runs three partial
//  products for each of the two fmix64 multiplies, one window at a time.
//  Reset clears the windows, the queue, the back end and sets k to 21 and
//  the threshold to all ones. full rises when the four-deep queue fills;
//  a result held by a stalled pop blocks the back end, then the front.
//
module canonical_kmer_hash_filter_unit (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              push,
  output logic                              full,
  input  ckhf_pkg::in_word_t                in_word,
  output logic                              empty,
  input  logic                              pop,
  output ckhf_pkg::out_word_t               out_word,
  input  logic                              cfg_we,
  input  logic [ckhf_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [ckhf_pkg::CFG_DATA_W-1:0]   cfg_wdata
);
  import ckhf_pkg::*;

  logic [KLEN_W-1:0] kmer_r;
  logic [HASH_W-1:0] thr_r;
  logic              kmer_wr;
  logic              in_take;
  logic              q_push, q_pop, q_empty;
  win_pair_t         q_wdata, q_rdata;

  // Writing k also empties the window.
  assign kmer_wr = cfg_we && (cfg_index == CFG_KMER_LENGTH);
  assign in_take = push && !full;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kmer_r <= KMER_RESET;
      thr_r  <= '1;
    end else if (cfg_we) begin
      // indexes past the list drop silently
      if (cfg_index == CFG_KMER_LENGTH) kmer_r <= cfg_wdata[KLEN_W-1:0];
      if (cfg_index == CFG_HASH_THRESHOLD) thr_r <= cfg_wdata[HASH_W-1:0];
    end
  end

  ckhf_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_take     (in_take),
    .in_word     (in_word),
    .kmer_length (kmer_r),
    .win_clear   (kmer_wr),
    .q_push      (q_push),
    .q_data      (q_wdata)
  );

  // Full whenever the queue is full, even for bases that would not enqueue.
  ckhf_fifo u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (q_push),
    .wr_data (q_wdata),
    .full    (full),
    .rd_en   (q_pop),
    .rd_data (q_rdata),
    .empty   (q_empty)
  );

  ckhf_hash u_hash (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .q_data    (q_rdata),
    .q_pop     (q_pop),
    .threshold (thr_r),
    .out_word  (out_word),
    .empty     (empty),
    .pop       (pop)
  );

endmodule

// ===== rtl/ckhf_front.sv =====
// ----------------------------------------------------------------------------
// ckhf_front
// Rolling forward and reverse-complement windows; queues full windows.
// ----------------------------------------------------------------------------
module ckhf_front (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_take,
  input  ckhf_pkg::in_word_t       in_word,
  input  logic [ckhf_pkg::KLEN_W-1:0] kmer_length,
  input  logic                     win_clear,
  output logic                     q_push,
  output ckhf_pkg::win_pair_t      q_data
);
  import ckhf_pkg::*;

  logic [HASH_W-1:0] fwd_r, fwd_nxt;
  logic [HASH_W-1:0] rev_r, rev_nxt;
  logic [KLEN_W-1:0] cnt_r, cnt_nxt;

  logic [KLEN_W-1:0] k_eff;
  logic [HASH_W-1:0] mask;
  logic [HASH_W-1:0] fwd_sh, rev_sh;
  logic [KLEN_W-1:0] cnt_inc;
  logic [KLEN_W-1:0] k_m1;
  base_code_t        bc;

  always_comb begin
    priority if (kmer_length == '0) k_eff = 6'd1;
    else if (kmer_length > KMER_MAX) k_eff = KMER_MAX;
    else k_eff = kmer_length;
  end

  assign k_m1    = k_eff - 6'd1;
  assign mask    = (k_eff == KMER_MAX) ? '1 : ((64'd1 << {k_eff, 1'b0}) - 64'd1);
  assign bc      = decode_base(in_word.base_char);
  assign fwd_sh  = ((fwd_r << 2) | {62'd0, bc.code}) & mask;
  assign rev_sh  = ((rev_r >> 2) | ({62'd0, 2'd3 - bc.code} << {k_m1, 1'b0})) & mask;
  assign cnt_inc = (cnt_r < KMER_MAX) ? cnt_r + 6'd1 : cnt_r;

  always_comb begin
    fwd_nxt = fwd_r;
    rev_nxt = rev_r;
    cnt_nxt = cnt_r;
    q_push  = 1'b0;
    q_data.fwd = fwd_sh;
    q_data.rev = rev_sh;
    priority if (win_clear) begin
      fwd_nxt = '0;
      rev_nxt = '0;
      cnt_nxt = '0;
    end else if (in_take) begin
      if (!bc.valid || in_word.last_base) begin
        fwd_nxt = '0;
        rev_nxt = '0;
        cnt_nxt = '0;
      end else begin
        fwd_nxt = fwd_sh;
        rev_nxt = rev_sh;
        cnt_nxt = cnt_inc;
      end
      q_push = bc.valid && (cnt_inc >= k_eff);
    end else begin
      // hold the window
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fwd_r <= '0;
      rev_r <= '0;
      cnt_r <= '0;
    end else begin
      fwd_r <= fwd_nxt;
      rev_r <= rev_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

// ===== rtl/ckhf_fifo.sv =====
// ----------------------------------------------------------------------------
// ckhf_fifo
// Short queue of window pairs between the front and the hash back end.
// ----------------------------------------------------------------------------
module ckhf_fifo (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                wr_en,
  input  ckhf_pkg::win_pair_t wr_data,
  output logic                full,
  input  logic                rd_en,
  output ckhf_pkg::win_pair_t rd_data,
  output logic                empty
);
  import ckhf_pkg::*;

  win_pair_t           mem [QDEPTH];
  logic [QPTR_W-1:0]   wp_r, rp_r;
  logic [QPTR_W:0]     cnt_r;
  logic                do_wr, do_rd;

  assign full    = (cnt_r == QPTR_W'(0) + (QPTR_W+1)'(QDEPTH));
  assign empty   = (cnt_r == '0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = mem[rp_r];

  always_ff @(posedge clk) begin
    if (do_wr) mem[wp_r] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (do_wr) wp_r <= wp_r + QPTR_W'(1);
      if (do_rd) rp_r <= rp_r + QPTR_W'(1);
      unique case ({do_wr, do_rd})
        2'b10:   cnt_r <= cnt_r + (QPTR_W+1)'(1);
        2'b01:   cnt_r <= cnt_r - (QPTR_W+1)'(1);
        default: cnt_r <= cnt_r;
      endcase
    end
  end

endmodule

// ===== rtl/ckhf_hash.sv =====
// ----------------------------------------------------------------------------
// ckhf_hash
// Iterative fmix64 of both windows, canonical minimum, threshold test; drops a pair in which either hash is all ones.
// ----------------------------------------------------------------------------
module ckhf_hash (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         q_empty,
  input  ckhf_pkg::win_pair_t          q_data,
  output logic                         q_pop,
  input  logic [ckhf_pkg::HASH_W-1:0]  threshold,
  output ckhf_pkg::out_word_t          out_word,
  output logic                         empty,
  input  logic                         pop
);
  import ckhf_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_MUL  = 2'd1;
  localparam logic [1:0] S_FIN  = 2'd2;
  localparam logic [1:0] S_OUT  = 2'd3;

  logic [1:0]        state_r, state_nxt;
  logic [1:0]        part_r, part_nxt;
  logic              round_r, round_nxt;
  logic [HASH_W-1:0] x_r    [2];
  logic [HASH_W-1:0] x_nxt  [2];
  logic [HASH_W-1:0] acc_r  [2];
  logic [HASH_W-1:0] acc_nxt[2];
  logic [HASH_W-1:0] prod_r [2];
  logic [HASH_W-1:0] prod_nxt[2];
  logic [HASH_W-1:0] acc_sum[2];
  logic [HASH_W-1:0] hmin_r, hmin_nxt;
  logic              drop_r, drop_nxt;
  out_word_t         ow_r, ow_nxt;
  logic              ov_r, ov_nxt;
  logic [HASH_W-1:0] cst;
  logic [31:0]       opa [2];
  logic [31:0]       opb;

  assign cst      = round_r ? FMIX_C2 : FMIX_C1;
  assign opb      = (part_r == 2'd1) ? cst[63:32] : cst[31:0];
  assign out_word = ow_r;
  assign empty    = !ov_r;

  always_comb begin
    for (int i = 0; i < 2; i++) begin
      opa[i]      = (part_r == 2'd2) ? x_r[i][63:32] : x_r[i][31:0];
      prod_nxt[i] = {32'd0, opa[i]} * {32'd0, opb};
      // low partial lands whole; cross partials only keep their low half
      acc_sum[i]  = (part_r == 2'd1) ? prod_r[i]
                                     : acc_r[i] + {prod_r[i][31:0], 32'd0};
    end
  end

  always_comb begin
    state_nxt = state_r;
    part_nxt  = part_r;
    round_nxt = round_r;
    hmin_nxt  = hmin_r;
    drop_nxt  = drop_r;
    ow_nxt    = ow_r;
    ov_nxt    = ov_r && !pop;
    q_pop     = 1'b0;
    for (int i = 0; i < 2; i++) begin
      x_nxt[i]   = x_r[i];
      acc_nxt[i] = acc_r[i];
    end
    unique case (state_r)
      S_IDLE: begin
        if (!q_empty) begin
          q_pop     = 1'b1;
          x_nxt[0]  = q_data.fwd ^ (q_data.fwd >> 33);
          x_nxt[1]  = q_data.rev ^ (q_data.rev >> 33);
          part_nxt  = 2'd0;
          round_nxt = 1'b0;
          state_nxt = S_MUL;
        end
      end
      S_MUL: begin
        for (int i = 0; i < 2; i++) begin
          if (part_r != 2'd0) acc_nxt[i] = acc_sum[i];
          if (part_r == 2'd3) x_nxt[i] = acc_sum[i] ^ (acc_sum[i] >> 33);
        end
        if (part_r == 2'd3) begin
          part_nxt = 2'd0;
          if (round_r) state_nxt = S_FIN;
          else round_nxt = 1'b1;
        end else begin
          part_nxt = part_r + 2'd1;
        end
      end
      S_FIN: begin
        drop_nxt  = (&x_r[0]) || (&x_r[1]);
        hmin_nxt  = (x_r[0] < x_r[1]) ? x_r[0] : x_r[1];
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (drop_r) begin
          state_nxt = S_IDLE;
        end else if (!ov_r || pop) begin
          ow_nxt.canonical_hash = hmin_r;
          ow_nxt.in_sketch      = (hmin_r <= threshold);
          ov_nxt                = 1'b1;
          state_nxt             = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 2; i++) begin
      x_r[i]    <= x_nxt[i];
      acc_r[i]  <= acc_nxt[i];
      prod_r[i] <= prod_nxt[i];
    end
    hmin_r <= hmin_nxt;
    drop_r <= drop_nxt;
    ow_r   <= ow_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      part_r  <= '0;
      round_r <= 1'b0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      part_r  <= part_nxt;
      round_r <= round_nxt;
      ov_r    <= ov_nxt;
    end
  end

endmodule
